// ===== rtl/gcr62_pkg.sv =====
// Package for the 6-and-2 GCR sector data field decoder.
// Holds field layout constants, the GCR code table, item types and the
// translation function. No dependencies.
package gcr62_pkg;

  // Field layout, counted in nibbles from the first auxiliary nibble.
  localparam int unsigned SECTOR_BYTES = 256;
  localparam int unsigned AUX_COUNT    = 86;
  localparam int unsigned POS_W        = 9;
  localparam int unsigned AUX_AW       = 7;

  localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(AUX_COUNT);
  localparam logic [POS_W-1:0] POS_CSUM       = POS_W'(AUX_COUNT + SECTOR_BYTES);
  localparam logic [POS_W-1:0] POS_EPI1       = POS_W'(AUX_COUNT + SECTOR_BYTES + 1);
  localparam logic [POS_W-1:0] POS_EPI2       = POS_W'(AUX_COUNT + SECTOR_BYTES + 2);
  localparam logic [POS_W-1:0] POS_DONE       = POS_W'(AUX_COUNT + SECTOR_BYTES + 3);

  // Data index boundaries between the three bit-pair groups.
  localparam logic [POS_W-1:0] J_GRP1 = POS_W'(AUX_COUNT);
  localparam logic [POS_W-1:0] J_GRP2 = POS_W'(2 * AUX_COUNT);

  localparam logic [7:0] EPI1_BYTE = 8'hDE;
  localparam logic [7:0] EPI2_BYTE = 8'hAA;
  localparam logic [7:0] BAD_CODE  = 8'hFF;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    GRP_BITS32 = 2'd0,
    GRP_BITS54 = 2'd1,
    GRP_BITS76 = 2'd2
  } grp_t;

  // One queued item: either a data byte still to be merged or the status.
  typedef struct packed {
    logic       is_status;
    logic       bad;
    logic [7:0] chained;
    logic [7:0] index;
    grp_t       grp;
    logic [7:0] aux;
  } q_item_t;

  localparam logic [7:0] GCR_CODES [64] = '{
    8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
    8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
    8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
    8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
    8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
    8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
    8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
    8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
  };

  // Six-bit code in bits 7..2, or BAD_CODE for a nibble outside the table.
  function automatic logic [7:0] gcr62_translate(input logic [7:0] nib);
    logic [7:0] res;
    res = BAD_CODE;
    for (int k = 0; k < 64; k++) begin
      if (GCR_CODES[k] == nib) begin
        res = {6'(k), 2'b00};
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/gcr62_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gcr62_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 86
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gcr62_front.sv =====
// Front part: accepts nibbles, translates and chains them, tracks the field
// position and error flag, and stores auxiliary values. Uses gcr62_pkg, gcr62_ram.
module gcr62_front
  import gcr62_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_nibble,
  input  logic       in_start,
  output logic       q_push,
  input  logic       q_ready,
  output q_item_t    q_item
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [7:0]       chain_r, chain_nxt, chain_eff;
  logic             err_r, err_nxt, err_eff;
  logic             s1_valid_r, s1_valid_nxt;
  q_item_t          s1_r, s1_nxt;
  logic [7:0]       code, chained;
  logic             code_bad, fire, load_s1;
  logic [POS_W-1:0] j9, j_m1, j_m2;
  grp_t             grp;
  logic [AUX_AW-1:0] aux_idx;
  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata;

  assign q_push    = s1_valid_r;
  assign in_tready = !s1_valid_r || q_ready;
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    pos_eff   = in_start ? '0 : pos_r;
    chain_eff = in_start ? '0 : chain_r;
    err_eff   = in_start ? 1'b0 : err_r;
    code      = gcr62_translate(in_nibble);
    code_bad  = (code == BAD_CODE);
    chained   = code ^ chain_eff;
    j9        = pos_eff - POS_DATA_FIRST;
    j_m1      = j9 - J_GRP1;
    j_m2      = j9 - J_GRP2;
    if (j9 < J_GRP1) begin
      grp     = GRP_BITS32;
      aux_idx = j9[AUX_AW-1:0];
    end else if (j9 < J_GRP2) begin
      grp     = GRP_BITS54;
      aux_idx = j_m1[AUX_AW-1:0];
    end else begin
      grp     = GRP_BITS76;
      aux_idx = j_m2[AUX_AW-1:0];
    end

    pos_nxt   = pos_eff;
    chain_nxt = chain_eff;
    err_nxt   = err_eff;
    load_s1   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    s1_nxt    = s1_r;

    if (pos_eff < POS_DATA_FIRST) begin
      err_nxt   = err_eff | code_bad;
      chain_nxt = chained;
      ram_we    = fire;
      pos_nxt   = pos_eff + 1'b1;
    end else if (pos_eff < POS_CSUM) begin
      err_nxt          = err_eff | code_bad;
      chain_nxt        = chained;
      ram_re           = fire;
      load_s1          = 1'b1;
      s1_nxt.is_status = 1'b0;
      s1_nxt.bad       = 1'b0;
      s1_nxt.chained   = chained;
      s1_nxt.index     = j9[7:0];
      s1_nxt.grp       = grp;
      s1_nxt.aux       = '0;
      pos_nxt          = pos_eff + 1'b1;
    end else if (pos_eff == POS_CSUM) begin
      err_nxt = err_eff | (chain_eff != code);
      pos_nxt = pos_eff + 1'b1;
    end else if (pos_eff == POS_EPI1) begin
      err_nxt = err_eff | (in_nibble != EPI1_BYTE);
      pos_nxt = pos_eff + 1'b1;
    end else if (pos_eff == POS_EPI2) begin
      err_nxt          = err_eff | (in_nibble != EPI2_BYTE);
      load_s1          = 1'b1;
      s1_nxt.is_status = 1'b1;
      s1_nxt.bad       = err_eff | (in_nibble != EPI2_BYTE);
      s1_nxt.chained   = '0;
      s1_nxt.index     = '0;
      s1_nxt.grp       = GRP_BITS32;
      s1_nxt.aux       = '0;
      pos_nxt          = POS_DONE;
    end

    s1_valid_nxt = (fire && load_s1) ? 1'b1 : (q_push && q_ready) ? 1'b0 : s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      chain_r    <= '0;
      err_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (fire) begin
        pos_r   <= pos_nxt;
        chain_r <= chain_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && load_s1) begin
      s1_r <= s1_nxt;
    end
  end

  // Auxiliary entries are read when the data nibble is taken; the read data
  // holds until the next data nibble, which is taken only as this one leaves.
  gcr62_ram #(
    .WIDTH (8),
    .DEPTH (AUX_COUNT)
  ) u_aux_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_eff[AUX_AW-1:0]),
    .wdata (chained),
    .re    (ram_re),
    .raddr (aux_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    q_item     = s1_r;
    q_item.aux = ram_rdata;
  end

endmodule

// ===== rtl/gcr62_queue.sv =====
// Short FIFO of decoded items between the front and back parts.
// Uses gcr62_pkg.
module gcr62_queue
  import gcr62_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    push_ready,
  input  q_item_t push_item,
  output logic    pop_valid,
  input  logic    pop,
  output q_item_t pop_item
);

  q_item_t           slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/gcr62_back.sv =====
// Back part: merges the rebuilt low bits into each data byte and holds the
// result in the output register. Uses gcr62_pkg.
module gcr62_back
  import gcr62_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  q_item_t     q_item,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser
);

  logic        out_valid_r;
  logic [15:0] data_r, data_nxt;
  logic [1:0]  user_r, user_nxt;
  logic [1:0]  pair;

  assign q_pop = q_valid && (!out_valid_r || out_tready);

  always_comb begin
    case (q_item.grp)
      GRP_BITS32: pair = q_item.aux[3:2];
      GRP_BITS54: pair = q_item.aux[5:4];
      GRP_BITS76: pair = q_item.aux[7:6];
      default:    pair = q_item.aux[7:6];
    endcase
    if (q_item.is_status) begin
      data_nxt = '0;
    end else begin
      data_nxt = {q_item.index, q_item.chained | {6'b0, pair[0], pair[1]}};
    end
    user_nxt = {q_item.bad, q_item.is_status};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

// ===== rtl/gcr_six_and_two_decoder.sv =====
// Top level of the 6-and-2 GCR sector data field decoder.
// Depends on gcr62_pkg, gcr62_front, gcr62_queue and gcr62_back.
//
// Usage: feed the raw nibbles of one sector data field on the in_ stream,
// one nibble per item, with in_tuser set on the first auxiliary nibble.
// A field is 86 auxiliary nibbles, 256 data nibbles, a checksum nibble and
// the two epilogue bytes, 345 items in all. Each data nibble yields one
// out_ item carrying the decoded byte and its index in the sector; the
// second epilogue byte yields one status item whose field_bad bit reports
// any invalid nibble, checksum mismatch or epilogue error. Other nibbles,
// and any nibbles after the status item until the next start marker,
// produce nothing.
// Throughput is one item per cycle while out_tready stays high. A data byte
// leaves through the auxiliary RAM read, the queue, then the output register.
// The front part keeps taking nibbles while the receiver stalls until the
// four-entry queue and its staging register fill; then in_tready drops.
// Reset clears the position, chain value, error flag, queue and output
// register; the auxiliary RAM is not cleared, since every entry is written
// before any data nibble reads it.
module gcr_six_and_two_decoder
  import gcr62_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] nibble
  input  logic [0:0]  in_tuser,   // [0] start_field
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] byte_value, [15:8] byte_index
  output logic [1:0]  out_tuser   // [0] is_status, [1] field_bad
);

  // Items cross from front to back through a short queue so that each side
  // can stall on its own.
  logic    fq_push, fq_ready;
  q_item_t fq_item;
  logic    qb_valid, qb_pop;
  q_item_t qb_item;

  gcr62_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_nibble (in_tdata),
    .in_start  (in_tuser[0]),
    .q_push    (fq_push),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  gcr62_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fq_push),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop        (qb_pop),
    .pop_item   (qb_item)
  );

  gcr62_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_pop      (qb_pop),
    .q_item     (qb_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
